// File: sv/jtsc_pkg.sv
`default_nettype none

package jtsc_pkg;

  localparam int MAX_DEPTH_DEF = 1024;

  localparam int KIND_W   = 3;
  localparam int STATUS_W = 4;
  localparam int DEPTH_W  = 11;
  localparam int MODE_W   = 4;
  localparam int PDATA_W  = 32;
  localparam int PADDR_W  = 3;

  // Register byte addresses
  localparam logic [PADDR_W-1:0] REG_TRAIL_COMMA = 3'd0;

  typedef enum logic [KIND_W-1:0] {
    K_VALUE = 3'd0,
    K_LBRK  = 3'd1,
    K_RBRK  = 3'd2,
    K_LBRC  = 3'd3,
    K_RBRC  = 3'd4,
    K_COLON = 3'd5,
    K_COMMA = 3'd6,
    K_END   = 3'd7
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 4'd0,
    ST_DONE       = 4'd1,
    ST_EXP_VALUE  = 4'd2,
    ST_EXP_STRING = 4'd3,
    ST_EXP_COLON  = 4'd4,
    ST_EXP_OBJSEP = 4'd5,
    ST_EXP_ARRSEP = 4'd6,
    ST_UNEXPECTED = 4'd7,
    ST_TOO_DEEP   = 4'd8,
    ST_IGNORED    = 4'd9
  } status_t;

  typedef enum logic [MODE_W-1:0] {
    M_TOP       = 4'd0,
    M_ARR_FIRST = 4'd1,
    M_ARR_NEXT  = 4'd2,
    M_OBJ_FIRST = 4'd3,
    M_OBJ_NEXT  = 4'd4,
    M_COLON     = 4'd5,
    M_OBJ_VAL   = 4'd6,
    M_AFTER     = 4'd7,
    M_FINISHED  = 4'd8,
    M_IGNORE    = 4'd9
  } mode_t;

  // Decoded effect of one token on the checker
  typedef struct packed {
    status_t status;
    logic    push;
    logic    pop;
    logic    push_obj;
    mode_t   mode_go;
  } act_t;

endpackage

`default_nettype wire

// File: sv/json_token_syntax_checker.sv
// Result: an accepted token's result word is registered in the output register,
//   or the skid stage under out_stall, shown on status/depth with out_valid high.
// Throughput: one token per cycle unless in_stall (skid full), set by the stack-top
//   register and the registered stack read prefetching the entry below the top.
// Reset (rst, synchronous): mode back to top-level value, depth zero, trailing comma
//   off, output and skid stages empty. The stack memory is not cleared.
`default_nettype none

module json_token_syntax_checker #(
  parameter int MAX_DEPTH = jtsc_pkg::MAX_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // config port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [jtsc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [jtsc_pkg::PDATA_W-1:0]  pwdata,
  output logic      [jtsc_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  // token input
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [jtsc_pkg::KIND_W-1:0]   kind,
  input  wire logic                          value_is_string,
  // result output
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [jtsc_pkg::STATUS_W-1:0] status,
  output logic      [jtsc_pkg::DEPTH_W-1:0]  depth
);

  // Count holds 0..MAX_DEPTH; memory holds entries below the top
  localparam int CW = $clog2(MAX_DEPTH + 1);
  localparam int AW = $clog2(MAX_DEPTH);

  // ---------------------------------------------------------------------------
  // Config register
  // ---------------------------------------------------------------------------
  logic trail_comma;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      trail_comma <= 1'b0;
    end else if (cfg_wr && paddr == jtsc_pkg::REG_TRAIL_COMMA) begin
      trail_comma <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == jtsc_pkg::REG_TRAIL_COMMA) begin
      prdata[0] = trail_comma;
    end
  end

  // ---------------------------------------------------------------------------
  // Checker state
  //   cnt   : open containers
  //   top   : type of innermost container (1 object, 0 array), valid when cnt>=1
  //   below : type of the one under it, prefetched from memory, valid when cnt>=2
  // ---------------------------------------------------------------------------
  jtsc_pkg::mode_t mode, mode_next;
  logic [CW-1:0]   cnt, cnt_next;
  logic            top, top_next;
  logic            below;

  jtsc_pkg::kind_t tok;
  jtsc_pkg::act_t  act;
  logic            acc;
  logic            full;
  jtsc_pkg::mode_t val_mode;
  jtsc_pkg::mode_t close_mode;

  assign tok  = jtsc_pkg::kind_t'(kind);
  assign acc  = in_valid && !in_stall;
  assign full = (cnt >= CW'(MAX_DEPTH));

  // where a finished value leaves us: nothing open means the document is done
  assign val_mode   = (cnt == '0) ? jtsc_pkg::M_FINISHED : jtsc_pkg::M_AFTER;
  assign close_mode = (cnt == CW'(1)) ? jtsc_pkg::M_FINISHED : jtsc_pkg::M_AFTER;

  function automatic jtsc_pkg::act_t take_value(
    input jtsc_pkg::kind_t k,
    input logic            is_full,
    input jtsc_pkg::mode_t vmode,
    input jtsc_pkg::mode_t cur
  );
    jtsc_pkg::act_t a;
    a = '{status: jtsc_pkg::ST_OK, push: 1'b0, pop: 1'b0, push_obj: 1'b0, mode_go: cur};
    if (k == jtsc_pkg::K_VALUE) begin
      a.mode_go = vmode;
    end else if (k == jtsc_pkg::K_LBRK || k == jtsc_pkg::K_LBRC) begin
      if (is_full) begin
        a.status = jtsc_pkg::ST_TOO_DEEP;
      end else begin
        a.push     = 1'b1;
        a.push_obj = (k == jtsc_pkg::K_LBRC);
        a.mode_go  = (k == jtsc_pkg::K_LBRC) ? jtsc_pkg::M_OBJ_FIRST
                                             : jtsc_pkg::M_ARR_FIRST;
      end
    end else begin
      a.status = jtsc_pkg::ST_EXP_VALUE;
    end
    return a;
  endfunction

  function automatic jtsc_pkg::act_t take_key(
    input jtsc_pkg::kind_t k,
    input logic            is_str,
    input jtsc_pkg::mode_t cur
  );
    jtsc_pkg::act_t a;
    a = '{status: jtsc_pkg::ST_OK, push: 1'b0, pop: 1'b0, push_obj: 1'b0, mode_go: cur};
    if (k == jtsc_pkg::K_VALUE && is_str) begin
      a.mode_go = jtsc_pkg::M_COLON;
    end else begin
      a.status = jtsc_pkg::ST_EXP_STRING;
    end
    return a;
  endfunction

  // Token decode: status and stack action for this token in the current mode
  always_comb begin
    act = '{status: jtsc_pkg::ST_OK, push: 1'b0, pop: 1'b0, push_obj: 1'b0,
            mode_go: mode};
    unique case (mode)
      jtsc_pkg::M_TOP, jtsc_pkg::M_OBJ_VAL: begin
        act = take_value(tok, full, val_mode, mode);
      end
      jtsc_pkg::M_ARR_FIRST, jtsc_pkg::M_ARR_NEXT: begin
        if (tok == jtsc_pkg::K_RBRK &&
            (mode == jtsc_pkg::M_ARR_FIRST || trail_comma)) begin
          act.pop     = 1'b1;
          act.mode_go = close_mode;
        end else begin
          act = take_value(tok, full, val_mode, mode);
        end
      end
      jtsc_pkg::M_OBJ_FIRST, jtsc_pkg::M_OBJ_NEXT: begin
        if (tok == jtsc_pkg::K_RBRC &&
            (mode == jtsc_pkg::M_OBJ_FIRST || trail_comma)) begin
          act.pop     = 1'b1;
          act.mode_go = close_mode;
        end else begin
          act = take_key(tok, value_is_string, mode);
        end
      end
      jtsc_pkg::M_COLON: begin
        if (tok == jtsc_pkg::K_COLON) begin
          act.mode_go = jtsc_pkg::M_OBJ_VAL;
        end else begin
          act.status = jtsc_pkg::ST_EXP_COLON;
        end
      end
      jtsc_pkg::M_AFTER: begin
        if (tok == jtsc_pkg::K_COMMA) begin
          act.mode_go = top ? jtsc_pkg::M_OBJ_NEXT : jtsc_pkg::M_ARR_NEXT;
        end else if (tok == (top ? jtsc_pkg::K_RBRC : jtsc_pkg::K_RBRK)) begin
          act.pop     = 1'b1;
          act.mode_go = close_mode;
        end else begin
          act.status = top ? jtsc_pkg::ST_EXP_OBJSEP : jtsc_pkg::ST_EXP_ARRSEP;
        end
      end
      jtsc_pkg::M_FINISHED: begin
        act.status = (tok == jtsc_pkg::K_END) ? jtsc_pkg::ST_DONE
                                              : jtsc_pkg::ST_UNEXPECTED;
      end
      jtsc_pkg::M_IGNORE: begin
        act.status = jtsc_pkg::ST_IGNORED;
      end
      default: begin
        act.status = jtsc_pkg::ST_IGNORED;
      end
    endcase
  end

  // Next state: end token always restarts, any error parks in ignore
  always_comb begin
    mode_next = act.mode_go;
    cnt_next  = cnt;
    top_next  = top;
    if (tok == jtsc_pkg::K_END) begin
      mode_next = jtsc_pkg::M_TOP;
      cnt_next  = '0;
    end else if (act.status != jtsc_pkg::ST_OK) begin
      mode_next = jtsc_pkg::M_IGNORE;
    end else if (act.push) begin
      cnt_next = cnt + CW'(1);
      top_next = act.push_obj;
    end else if (act.pop) begin
      cnt_next = cnt - CW'(1);
      top_next = below;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= jtsc_pkg::M_TOP;
      cnt  <= '0;
    end else if (acc) begin
      mode <= mode_next;
      cnt  <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      top <= top_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Container stack memory: entries 0..cnt-2 (the top lives in a register)
  // ---------------------------------------------------------------------------
  logic          stk_mem [MAX_DEPTH];
  logic          stk_we;
  logic [CW-1:0] waddr_full;
  logic [CW-1:0] raddr_full;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  // a push spills the old top one slot down
  assign stk_we     = acc && act.push && (tok != jtsc_pkg::K_END) && (cnt != '0);
  assign waddr_full = cnt - CW'(1);
  assign waddr      = waddr_full[AW-1:0];
  // prefetch the entry under the next top
  assign raddr_full = (acc ? cnt_next : cnt) - CW'(2);
  assign raddr      = raddr_full[AW-1:0];

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[waddr] <= top;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && act.push) begin
      below <= top;                 // read of the slot being written
    end else begin
      below <= stk_mem[raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Result word: output register plus skid stage
  // ---------------------------------------------------------------------------
  logic                         res_valid;
  logic [jtsc_pkg::STATUS_W-1:0] res_status;
  logic [jtsc_pkg::DEPTH_W-1:0]  res_depth;
  logic                         skid_valid;
  logic [jtsc_pkg::STATUS_W-1:0] skid_status;
  logic [jtsc_pkg::DEPTH_W-1:0]  skid_depth;
  logic                         res_free;
  logic [jtsc_pkg::DEPTH_W-1:0]  new_depth;

  assign new_depth = jtsc_pkg::DEPTH_W'(cnt_next);
  assign res_free  = !res_valid || !out_stall;
  assign in_stall  = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (res_free) begin
      res_valid  <= skid_valid || acc;
      skid_valid <= 1'b0;
    end else if (acc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free) begin
      if (skid_valid) begin
        res_status <= skid_status;
        res_depth  <= skid_depth;
      end else if (acc) begin
        res_status <= act.status;
        res_depth  <= new_depth;
      end
    end else if (acc) begin
      skid_status <= act.status;
      skid_depth  <= new_depth;
    end
  end

  assign out_valid = res_valid;
  assign status    = res_status;
  assign depth     = res_depth;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_behind_res: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid stage holds a word while output register is empty");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_DEPTH))
    else $error("open container count past bound");

  a_inside_container: assert property (@(posedge clk) disable iff (rst)
    (mode == jtsc_pkg::M_ARR_FIRST || mode == jtsc_pkg::M_ARR_NEXT ||
     mode == jtsc_pkg::M_OBJ_FIRST || mode == jtsc_pkg::M_OBJ_NEXT ||
     mode == jtsc_pkg::M_COLON || mode == jtsc_pkg::M_OBJ_VAL ||
     mode == jtsc_pkg::M_AFTER) |-> cnt != '0)
    else $error("container mode with no container open");

  a_finished_flat: assert property (@(posedge clk) disable iff (rst)
    mode == jtsc_pkg::M_FINISHED |-> cnt == '0)
    else $error("document finished with containers open");

  // old top is only meaningful with a container already open
  a_push_top: assert property (@(posedge clk) disable iff (rst)
    (acc && act.push && tok != jtsc_pkg::K_END && cnt != '0) |=>
      (top == $past(act.push_obj) && below == $past(top)))
    else $error("stack top not updated on open");

endmodule

`default_nettype wire
